// File: rtl/wtsp_pkg.sv
// Shared constants and types for the world-to-screen projection core.
`default_nettype none
package wtsp_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int COEF_FRAC_BITS  = 12;

    // field widths
    localparam int POS_W   = 32;
    localparam int COEF_W  = 16;
    localparam int ROW_W   = 4 * COEF_W;
    localparam int DIM_W   = 12;
    localparam int SCR_W   = 16;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = ROW_W;

    // datapath widths
    localparam int PROD_W  = POS_W + COEF_W;
    localparam int DOT_W   = PROD_W + 2;
    localparam int MAG_W   = DOT_W - 1;
    localparam int QUO_FRAC = 16;
    localparam int HUGE_SH  = 15;
    localparam int QUO_W    = HUGE_SH + QUO_FRAC;
    localparam int PX_W     = QUO_W + DIM_W;
    localparam int RND_SH   = QUO_FRAC - 3;
    localparam int TERM_W   = PX_W - RND_SH + 1;
    localparam int SUM_W    = TERM_W + 3;

    localparam logic [63:0] VIS_MIN_U =
        (64'd1 << (COORD_FRAC_BITS + COEF_FRAC_BITS)) / 64'd100;
    localparam logic [PX_W-1:0]   RND_ADD  = PX_W'(1) << (RND_SH - 1);
    localparam logic [TERM_W-1:0] BIG_TERM = TERM_W'(1) << 18;
    localparam logic signed [SCR_W-1:0] HIDDEN_POS = -SCR_W'(16);
    localparam logic signed [SCR_W-1:0] SCR_MAX = {1'b0, {(SCR_W-1){1'b1}}};
    localparam logic signed [SCR_W-1:0] SCR_MIN = {1'b1, {(SCR_W-1){1'b0}}};

    // configuration register indexes
    localparam logic [CFG_AW-1:0] REG_ROW_X    = 3'd0;
    localparam logic [CFG_AW-1:0] REG_ROW_Y    = 3'd1;
    localparam logic [CFG_AW-1:0] REG_ROW_W    = 3'd2;
    localparam logic [CFG_AW-1:0] REG_VIEW_W   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_VIEW_H   = 3'd4;
    localparam logic [CFG_AW-1:0] REG_ORIGIN_X = 3'd5;
    localparam logic [CFG_AW-1:0] REG_ORIGIN_Y = 3'd6;

    localparam logic [DIM_W-1:0] VIEW_W_RST = 12'd1920;
    localparam logic [DIM_W-1:0] VIEW_H_RST = 12'd1080;

    // payload of one divider stage; quotient bits shift in behind dividend bits
    typedef struct packed {
        logic [MAG_W-1:0] den;
        logic [MAG_W-1:0] rx;
        logic [MAG_W-1:0] ry;
        logic [QUO_W-1:0] zx;
        logic [QUO_W-1:0] zy;
        logic             negx;
        logic             negy;
        logic             hugex;
        logic             hugey;
        logic             vis;
    } t_div;

endpackage
`default_nettype wire

// File: rtl/world_to_screen_projection_core.sv
// Pipelined world-to-screen perspective projection core.
// Stages, in order; each divider stage resolves one quotient bit:
//   multiply, row sum, abs/prep, 31 restoring-divider stages, scale, output.
// Throughput: one point per cycle when i_ready does not stall the output.
// Reset (synchronous, active low) empties the pipeline and loads the
//   configuration defaults: rows zero, 1920x1080 viewport, zero origin.
`default_nettype none
module world_to_screen_projection_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [wtsp_pkg::CFG_AW-1:0]         i_cfg_addr,
    input  wire logic [wtsp_pkg::CFG_DW-1:0]         i_cfg_wdata,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [wtsp_pkg::POS_W-1:0]   i_pos_x,
    input  wire logic signed [wtsp_pkg::POS_W-1:0]   i_pos_y,
    input  wire logic signed [wtsp_pkg::POS_W-1:0]   i_pos_z,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [wtsp_pkg::SCR_W-1:0]        o_screen_x,
    output logic signed [wtsp_pkg::SCR_W-1:0]        o_screen_y,
    output logic                                     o_visible
);

    localparam int MAG_W  = wtsp_pkg::MAG_W;
    localparam int DOT_W  = wtsp_pkg::DOT_W;
    localparam int QUO_W  = wtsp_pkg::QUO_W;
    localparam int PROD_W = wtsp_pkg::PROD_W;
    localparam int COEF_W = wtsp_pkg::COEF_W;
    localparam int PX_W   = wtsp_pkg::PX_W;
    localparam int TERM_W = wtsp_pkg::TERM_W;
    localparam int SUM_W  = wtsp_pkg::SUM_W;
    localparam int SCR_W  = wtsp_pkg::SCR_W;
    localparam int DIM_W  = wtsp_pkg::DIM_W;
    localparam int HUGE_SH = wtsp_pkg::HUGE_SH;
    localparam int QUO_FRAC = wtsp_pkg::QUO_FRAC;
    localparam logic signed [DOT_W-1:0] VIS_MIN = DOT_W'(wtsp_pkg::VIS_MIN_U);

    // configuration
    logic [wtsp_pkg::ROW_W-1:0] r_row [0:2];
    logic [DIM_W-1:0]           r_view_w, r_view_h;
    logic signed [DIM_W-1:0]    r_org_x, r_org_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= '0;
            r_row[1] <= '0;
            r_row[2] <= '0;
            r_view_w <= wtsp_pkg::VIEW_W_RST;
            r_view_h <= wtsp_pkg::VIEW_H_RST;
            r_org_x  <= '0;
            r_org_y  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                wtsp_pkg::REG_ROW_X:    r_row[0] <= i_cfg_wdata;
                wtsp_pkg::REG_ROW_Y:    r_row[1] <= i_cfg_wdata;
                wtsp_pkg::REG_ROW_W:    r_row[2] <= i_cfg_wdata;
                wtsp_pkg::REG_VIEW_W:   r_view_w <= i_cfg_wdata[DIM_W-1:0];
                wtsp_pkg::REG_VIEW_H:   r_view_h <= i_cfg_wdata[DIM_W-1:0];
                wtsp_pkg::REG_ORIGIN_X: r_org_x  <= i_cfg_wdata[DIM_W-1:0];
                wtsp_pkg::REG_ORIGIN_Y: r_org_y  <= i_cfg_wdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // stage registers
    logic                     r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_o_vld;
    logic signed [PROD_W-1:0] r_s1_prod [0:2][0:2];
    logic signed [DOT_W-1:0]  r_s2_dot [0:2];
    wtsp_pkg::t_div           r_s3;
    logic                     r_dv_vld [0:QUO_W-1];
    wtsp_pkg::t_div           r_dv     [0:QUO_W-1];
    logic [PX_W-1:0]          r_s4_px, r_s4_py;
    logic                     r_s4_negx, r_s4_negy, r_s4_hx, r_s4_hy, r_s4_vis;
    logic signed [SCR_W-1:0]  r_o_sx, r_o_sy;
    logic                     r_o_vis;

    // per-stage ready chain: a stage takes data when empty or draining
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy_o;
    logic w_rdy_dv [0:QUO_W-1];

    assign w_rdy_o = !r_o_vld  || i_ready;
    assign w_rdy4  = !r_s4_vld || w_rdy_o;
    assign w_rdy3  = !r_s3_vld || w_rdy_dv[0];
    assign w_rdy2  = !r_s2_vld || w_rdy3;
    assign w_rdy1  = !r_s1_vld || w_rdy2;
    assign o_ready = w_rdy1;

    // stage 1: nine coefficient products
    logic signed [PROD_W-1:0] n_prod [0:2][0:2];
    logic signed [wtsp_pkg::POS_W-1:0] w_pos [0:2];
    assign w_pos[0] = i_pos_x;
    assign w_pos[1] = i_pos_y;
    assign w_pos[2] = i_pos_z;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                n_prod[r][k] = PROD_W'($signed(r_row[r][COEF_W*k +: COEF_W]))
                             * PROD_W'(w_pos[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_rdy1) begin
            r_s1_vld <= i_valid;
        end
        if (w_rdy1) begin
            r_s1_prod <= n_prod;
        end
    end

    // stage 2: row sums plus translation
    logic signed [DOT_W-1:0] n_dot [0:2];
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_dot[r] = (DOT_W'($signed(r_row[r][COEF_W*3 +: COEF_W]))
                        <<< wtsp_pkg::COORD_FRAC_BITS)
                     + DOT_W'(r_s1_prod[r][0]) + DOT_W'(r_s1_prod[r][1])
                     + DOT_W'(r_s1_prod[r][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_rdy2) begin
            r_s2_vld <= r_s1_vld;
        end
        if (w_rdy2) begin
            r_s2_dot <= n_dot;
        end
    end

    // stage 3: magnitudes, visibility, divider seed
    wtsp_pkg::t_div n_s3;
    logic [DOT_W-1:0] w_ax, w_ay;
    always_comb begin
        w_ax = r_s2_dot[0][DOT_W-1] ? DOT_W'(-r_s2_dot[0]) : DOT_W'(r_s2_dot[0]);
        w_ay = r_s2_dot[1][DOT_W-1] ? DOT_W'(-r_s2_dot[1]) : DOT_W'(r_s2_dot[1]);
        n_s3.den   = r_s2_dot[2][MAG_W-1:0];
        n_s3.rx    = MAG_W'(w_ax >> HUGE_SH);
        n_s3.ry    = MAG_W'(w_ay >> HUGE_SH);
        n_s3.zx    = {w_ax[HUGE_SH-1:0], QUO_FRAC'(0)};
        n_s3.zy    = {w_ay[HUGE_SH-1:0], QUO_FRAC'(0)};
        n_s3.negx  = r_s2_dot[0][DOT_W-1];
        n_s3.negy  = r_s2_dot[1][DOT_W-1];
        n_s3.hugex = MAG_W'(w_ax >> HUGE_SH) >= r_s2_dot[2][MAG_W-1:0];
        n_s3.hugey = MAG_W'(w_ay >> HUGE_SH) >= r_s2_dot[2][MAG_W-1:0];
        n_s3.vis   = r_s2_dot[2] > VIS_MIN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (w_rdy3) begin
            r_s3_vld <= r_s2_vld;
        end
        if (w_rdy3) begin
            r_s3 <= n_s3;
        end
    end

    // one restoring step: returns {quotient bit, new remainder}
    function automatic logic [MAG_W:0] div_step(input logic [MAG_W-1:0] rem,
                                                input logic bit_in,
                                                input logic [MAG_W-1:0] den);
        logic [MAG_W:0] t;
        logic [MAG_W:0] d;
        t = {rem, bit_in};
        d = {1'b0, den};
        if (t >= d) begin
            div_step = {1'b1, MAG_W'(t - d)};
        end else begin
            div_step = {1'b0, t[MAG_W-1:0]};
        end
    endfunction

    // divider stages
    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        wtsp_pkg::t_div d_in, d_nx;
        logic           v_in;
        logic           rdy_next;
        logic [MAG_W:0] sx, sy;

        if (k == 0) begin : g_first
            assign d_in = r_s3;
            assign v_in = r_s3_vld;
        end else begin : g_mid
            assign d_in = r_dv[k-1];
            assign v_in = r_dv_vld[k-1];
        end
        if (k == QUO_W - 1) begin : g_last
            assign rdy_next = w_rdy4;
        end else begin : g_more
            assign rdy_next = w_rdy_dv[k+1];
        end

        assign w_rdy_dv[k] = !r_dv_vld[k] || rdy_next;

        always_comb begin
            sx = div_step(d_in.rx, d_in.zx[QUO_W-1], d_in.den);
            sy = div_step(d_in.ry, d_in.zy[QUO_W-1], d_in.den);
            d_nx    = d_in;
            d_nx.rx = sx[MAG_W-1:0];
            d_nx.ry = sy[MAG_W-1:0];
            d_nx.zx = {d_in.zx[QUO_W-2:0], sx[MAG_W]};
            d_nx.zy = {d_in.zy[QUO_W-2:0], sy[MAG_W]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k] <= 1'b0;
            end else if (w_rdy_dv[k]) begin
                r_dv_vld[k] <= v_in;
            end
            if (w_rdy_dv[k]) begin
                r_dv[k] <= d_nx;
            end
        end
    end

    // stage 4: scale quotients by viewport size
    wtsp_pkg::t_div w_dq;
    assign w_dq = r_dv[QUO_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (w_rdy4) begin
            r_s4_vld <= r_dv_vld[QUO_W-1];
        end
        if (w_rdy4) begin
            r_s4_px   <= PX_W'(r_view_w) * PX_W'(w_dq.zx);
            r_s4_py   <= PX_W'(r_view_h) * PX_W'(w_dq.zy);
            r_s4_negx <= w_dq.negx;
            r_s4_negy <= w_dq.negy;
            r_s4_hx   <= w_dq.hugex;
            r_s4_hy   <= w_dq.hugey;
            r_s4_vis  <= w_dq.vis;
        end
    end

    // output stage: round, offset, saturate; invisible points get HIDDEN_POS
    function automatic logic signed [SCR_W-1:0] sat(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(wtsp_pkg::SCR_MAX)) begin
            sat = wtsp_pkg::SCR_MAX;
        end else if (v < SUM_W'(wtsp_pkg::SCR_MIN)) begin
            sat = wtsp_pkg::SCR_MIN;
        end else begin
            sat = v[SCR_W-1:0];
        end
    endfunction

    logic [TERM_W-1:0]       w_mx, w_my;
    logic signed [SUM_W-1:0] w_tx, w_ty, w_bx, w_by;
    logic signed [SCR_W-1:0] n_sx, n_sy;

    always_comb begin
        if (r_view_w == '0) begin
            w_mx = '0;
        end else if (r_s4_hx) begin
            w_mx = wtsp_pkg::BIG_TERM;
        end else begin
            w_mx = TERM_W'((r_s4_px + wtsp_pkg::RND_ADD) >> wtsp_pkg::RND_SH);
        end
        if (r_view_h == '0) begin
            w_my = '0;
        end else if (r_s4_hy) begin
            w_my = wtsp_pkg::BIG_TERM;
        end else begin
            w_my = TERM_W'((r_s4_py + wtsp_pkg::RND_ADD) >> wtsp_pkg::RND_SH);
        end
        w_tx = r_s4_negx ? -$signed(SUM_W'(w_mx)) : $signed(SUM_W'(w_mx));
        w_ty = r_s4_negy ? -$signed(SUM_W'(w_my)) : $signed(SUM_W'(w_my));
        w_bx = $signed((SUM_W'(r_view_w) + SUM_W'(1)) << 3)
             + (SUM_W'(r_org_x) <<< 4);
        w_by = $signed((SUM_W'(r_view_h) - SUM_W'(1)) << 3)
             + (SUM_W'(r_org_y) <<< 4);
        if (r_s4_vis) begin
            n_sx = sat(w_bx + w_tx);
            n_sy = sat(w_by - w_ty);
        end else begin
            n_sx = wtsp_pkg::HIDDEN_POS;
            n_sy = wtsp_pkg::HIDDEN_POS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_rdy_o) begin
            r_o_vld <= r_s4_vld;
        end
        if (w_rdy_o) begin
            r_o_sx  <= n_sx;
            r_o_sy  <= n_sy;
            r_o_vis <= r_s4_vis;
        end
    end

    assign o_valid    = r_o_vld;
    assign o_screen_x = r_o_sx;
    assign o_screen_y = r_o_sy;
    assign o_visible  = r_o_vis;

`ifndef SYNTHESIS
    a_hidden_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_visible |->
            o_screen_x == wtsp_pkg::HIDDEN_POS && o_screen_y == wtsp_pkg::HIDDEN_POS)
        else $error("hidden point not at -1,-1");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_huge_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_vld && w_rdy_o && r_s4_vis && r_s4_hx && r_view_w != '0 |=>
            o_screen_x == wtsp_pkg::SCR_MAX || o_screen_x == wtsp_pkg::SCR_MIN)
        else $error("huge ratio did not saturate");

    a_s4_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_vld && !w_rdy4 |=> r_s4_vld && $stable(r_s4_px))
        else $error("stalled scale stage lost its data");
`endif

endmodule
`default_nettype wire

// File: bench/wtsp_checker.sv
// Output checker for the world-to-screen projection core: predicts each point and compares.
`timescale 1ns / 1ps
`default_nettype none
module wtsp_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [wtsp_pkg::CFG_AW-1:0]         i_cfg_addr,
    input  wire logic [wtsp_pkg::CFG_DW-1:0]         i_cfg_wdata,
    input  wire logic                                i_in_valid,
    input  wire logic                                i_in_ready,
    input  wire logic signed [wtsp_pkg::POS_W-1:0]   i_pos_x,
    input  wire logic signed [wtsp_pkg::POS_W-1:0]   i_pos_y,
    input  wire logic signed [wtsp_pkg::POS_W-1:0]   i_pos_z,
    input  wire logic                                i_out_valid,
    input  wire logic                                i_out_ready,
    input  wire logic signed [wtsp_pkg::SCR_W-1:0]   i_screen_x,
    input  wire logic signed [wtsp_pkg::SCR_W-1:0]   i_screen_y,
    input  wire logic                                i_visible,
    output int                                       o_errors,
    output int                                       o_pending
);

    typedef struct packed {
        logic signed [wtsp_pkg::SCR_W-1:0] sx;
        logic signed [wtsp_pkg::SCR_W-1:0] sy;
        logic                              vis;
    } t_pixel;

    logic [wtsp_pkg::ROW_W-1:0] row_x, row_y, row_w;
    logic [wtsp_pkg::DIM_W-1:0] view_w, view_h;
    logic signed [wtsp_pkg::DIM_W-1:0] org_x, org_y;
    t_pixel pixel_q[$];

    function automatic longint row_dot(logic [wtsp_pkg::ROW_W-1:0] row, longint px,
                                       longint py, longint pz);
        longint acc;
        acc = longint'($signed(row[63:48])) * (longint'(1) << wtsp_pkg::COORD_FRAC_BITS);
        acc += longint'($signed(row[15:0])) * px;
        acc += longint'($signed(row[31:16])) * py;
        acc += longint'($signed(row[47:32])) * pz;
        return acc;
    endfunction

    // Q.4 value of num*dim/(2*den), quotient truncated to 16 fraction bits
    function automatic longint scaled_term(longint num, longint den, longint dim);
        logic [63:0] a, q, r, mag;
        a = (num < 0) ? 64'(-num) : 64'(num);
        if (dim == 0) begin
            mag = 0;
        end else if (a >= (64'(den) << 15)) begin
            mag = 64'd262144;
        end else begin
            q = a / 64'(den);
            r = a % 64'(den);
            repeat (16) begin
                r = r << 1;
                q = q << 1;
                if (r >= 64'(den)) begin
                    r -= 64'(den);
                    q[0] = 1'b1;
                end
            end
            mag = (64'(dim) * q + 64'd4096) >> 13;
        end
        return (num < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic logic signed [wtsp_pkg::SCR_W-1:0] clamp16(longint v);
        if (v > 32767) return wtsp_pkg::SCR_MAX;
        if (v < -32768) return wtsp_pkg::SCR_MIN;
        return wtsp_pkg::SCR_W'(v);
    endfunction

    function automatic t_pixel project_point(longint px, longint py, longint pz);
        t_pixel p;
        longint xr, yr, wr;
        xr = row_dot(row_x, px, py, pz);
        yr = row_dot(row_y, px, py, pz);
        wr = row_dot(row_w, px, py, pz);
        if (wr > 0 && wr * 100 >
            (longint'(1) << (wtsp_pkg::COORD_FRAC_BITS + wtsp_pkg::COEF_FRAC_BITS))) begin
            p.sx = clamp16(8 * (longint'(view_w) + 1) + 16 * longint'(org_x)
                           + scaled_term(xr, wr, longint'(view_w)));
            p.sy = clamp16(8 * (longint'(view_h) - 1) + 16 * longint'(org_y)
                           - scaled_term(yr, wr, longint'(view_h)));
            p.vis = 1'b1;
        end else begin
            p.sx = wtsp_pkg::HIDDEN_POS;
            p.sy = wtsp_pkg::HIDDEN_POS;
            p.vis = 1'b0;
        end
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_pixel exp_p;
        if (!i_rst_n) begin
            row_x <= '0;
            row_y <= '0;
            row_w <= '0;
            view_w <= wtsp_pkg::VIEW_W_RST;
            view_h <= wtsp_pkg::VIEW_H_RST;
            org_x <= '0;
            org_y <= '0;
            o_errors <= 0;
            pixel_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    wtsp_pkg::REG_ROW_X:    row_x <= i_cfg_wdata;
                    wtsp_pkg::REG_ROW_Y:    row_y <= i_cfg_wdata;
                    wtsp_pkg::REG_ROW_W:    row_w <= i_cfg_wdata;
                    wtsp_pkg::REG_VIEW_W:   view_w <= i_cfg_wdata[wtsp_pkg::DIM_W-1:0];
                    wtsp_pkg::REG_VIEW_H:   view_h <= i_cfg_wdata[wtsp_pkg::DIM_W-1:0];
                    wtsp_pkg::REG_ORIGIN_X: org_x <= i_cfg_wdata[wtsp_pkg::DIM_W-1:0];
                    wtsp_pkg::REG_ORIGIN_Y: org_y <= i_cfg_wdata[wtsp_pkg::DIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                pixel_q.push_back(project_point(i_pos_x, i_pos_y, i_pos_z));
            if (i_out_valid && i_out_ready) begin
                if (pixel_q.size() == 0) begin
                    $error("unexpected transfer: screen_x %0d screen_y %0d visible %0b",
                           i_screen_x, i_screen_y, i_visible);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_p = pixel_q.pop_front();
                    if (exp_p.sx !== i_screen_x)
                        $error("screen_x expected %0d actual %0d", exp_p.sx, i_screen_x);
                    if (exp_p.sy !== i_screen_y)
                        $error("screen_y expected %0d actual %0d", exp_p.sy, i_screen_y);
                    if (exp_p.vis !== i_visible)
                        $error("visible expected %0b actual %0b", exp_p.vis, i_visible);
                    if (exp_p !== {i_screen_x, i_screen_y, i_visible})
                        o_errors <= o_errors + 1;
                end
            end
        end
        o_pending <= pixel_q.size();
    end

endmodule
`default_nettype wire

// File: bench/tb_world_to_screen_projection_core.sv
// Testbench top for the world-to-screen projection core: stimulus, config phases, verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_world_to_screen_projection_core;

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [wtsp_pkg::CFG_AW-1:0] i_cfg_addr;
    logic [wtsp_pkg::CFG_DW-1:0] i_cfg_wdata;
    logic i_valid, o_ready, o_valid, i_ready;
    logic signed [wtsp_pkg::POS_W-1:0] i_pos_x, i_pos_y, i_pos_z;
    logic signed [wtsp_pkg::SCR_W-1:0] o_screen_x, o_screen_y;
    logic o_visible;
    int errors, pending;
    int hold_off;   // >0: receiver blocked until it counts down to zero
    bit rx_idle_on; // random receiver bursts enabled

    world_to_screen_projection_core dut (.*);

    wtsp_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_addr, .i_cfg_wdata,
        .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_pos_x, .i_pos_y, .i_pos_z,
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_screen_x(o_screen_x), .i_screen_y(o_screen_y), .i_visible(o_visible),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("tb_world_to_screen_projection_core failed");
        $finish;
    end

    // receiver: random stall bursts, plus a long hold-off when asked
    initial begin
        int gap;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off > 0) begin
                i_ready <= 1'b0;
                hold_off = hold_off - 1;
            end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 15);
                i_ready <= 1'b0;
                repeat (gap - 1) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic [wtsp_pkg::CFG_AW-1:0] idx,
                             logic [wtsp_pkg::CFG_DW-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // pending is registered, so look only after the last transfer is counted
    task automatic drain_pipe();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // one point; optional random gap before it
    task automatic send_point(logic [wtsp_pkg::POS_W-1:0] px, logic [wtsp_pkg::POS_W-1:0] py,
                              logic [wtsp_pkg::POS_W-1:0] pz, bit may_gap);
        if (may_gap && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pos_x <= px;
        i_pos_y <= py;
        i_pos_z <= pz;
        do @(posedge i_clk); while (!o_ready);
    endtask

    function automatic logic [wtsp_pkg::POS_W-1:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return wtsp_pkg::POS_W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
            3: return wtsp_pkg::POS_W'({$urandom_range(0, 1), 31'h0}) | $urandom_range(0, 1);
            default: return wtsp_pkg::POS_W'($signed(32'($urandom_range(0, 200) - 100)) <<< 16);
        endcase
    endfunction

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 3))
            0: return 16'($urandom());
            1: return 16'($signed($urandom_range(0, 8192)) - 4096);
            2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom_range(0, 1) ? 4096 : 0);
        endcase
    endfunction

    // w row leans positive so most points end up visible
    task automatic random_config(bit extreme);
        logic [wtsp_pkg::ROW_W-1:0] wr;
        wr = {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
        if ($urandom_range(0, 3) != 0)
            wr = {16'($urandom_range(256, 32767)), 16'($urandom_range(0, 64)), 16'h0, 16'h0};
        write_reg(wtsp_pkg::REG_ROW_X, {rand_coef(), rand_coef(), rand_coef(), rand_coef()});
        write_reg(wtsp_pkg::REG_ROW_Y, {rand_coef(), rand_coef(), rand_coef(), rand_coef()});
        write_reg(wtsp_pkg::REG_ROW_W, wr);
        write_reg(wtsp_pkg::REG_VIEW_W,
                  extreme ? wtsp_pkg::CFG_DW'($urandom_range(0, 1) ? 4095 : 0)
                          : wtsp_pkg::CFG_DW'($urandom_range(0, 4095)));
        write_reg(wtsp_pkg::REG_VIEW_H,
                  extreme ? wtsp_pkg::CFG_DW'($urandom_range(0, 1) ? 4095 : 0)
                          : wtsp_pkg::CFG_DW'($urandom_range(0, 4095)));
        write_reg(wtsp_pkg::REG_ORIGIN_X,
                  extreme ? wtsp_pkg::CFG_DW'($urandom_range(0, 1) ? 12'h7ff : 12'h800)
                          : {52'($urandom()), 12'($urandom())});
        write_reg(wtsp_pkg::REG_ORIGIN_Y,
                  extreme ? wtsp_pkg::CFG_DW'($urandom_range(0, 1) ? 12'h7ff : 12'h800)
                          : {52'($urandom()), 12'($urandom())});
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        i_valid = 1'b0;
        i_pos_x = '0;
        i_pos_y = '0;
        i_pos_z = '0;
        hold_off = 0;
        rx_idle_on = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: zero rows, every point hidden
        send_point(32'h7fffffff, 32'h80000000, 32'h0, 0);
        i_valid <= 1'b0;
        drain_pipe();

        // identity-like view: x, y pass, w = 1 + z
        write_reg(wtsp_pkg::REG_ROW_X, {16'h0, 16'h0, 16'h0, 16'h1000});
        write_reg(wtsp_pkg::REG_ROW_Y, {16'h0, 16'h0, 16'h1000, 16'h0});
        write_reg(wtsp_pkg::REG_ROW_W, {16'h1000, 16'h1000, 16'h0, 16'h0});
        write_reg(wtsp_pkg::REG_VIEW_W, 64'd1920);
        write_reg(wtsp_pkg::REG_VIEW_H, 64'd1080);
        write_reg(wtsp_pkg::REG_ORIGIN_X, 64'hfff);
        write_reg(wtsp_pkg::REG_ORIGIN_Y, 64'h7ff);
        write_reg(3'd7, 64'hffffffffffffffff);   // unmapped index, no effect
        send_point(32'h0, 32'h0, 32'h0, 0);                 // center
        send_point(32'h00010000, 32'hffff0000, 32'h0, 0);   // corners
        send_point(32'h7fffffff, 32'h80000000, 32'h0, 0);   // huge ratio
        send_point(32'h80000000, 32'h7fffffff, 32'h0, 0);
        send_point(32'h0, 32'h0, 32'hffff0000, 0);          // w = 0
        send_point(32'h0, 32'h0, 32'hffff028f, 0);          // w just below threshold
        send_point(32'h0, 32'h0, 32'hffff0290, 0);          // w just above
        send_point(32'h0, 32'h0, 32'h80000000, 0);          // w negative
        send_point(32'h12345678, 32'hedcba987, 32'h7fffffff, 0);
        send_point(32'h00008000, 32'hffff8000, 32'h0, 0);   // half-unit x and y
        i_valid <= 1'b0;
        drain_pipe();

        // extreme coefficients and zero / full viewport
        for (int ph = 0; ph < 2; ph++) begin
            write_reg(wtsp_pkg::REG_ROW_X, {16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
            write_reg(wtsp_pkg::REG_ROW_Y, {16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
            write_reg(wtsp_pkg::REG_ROW_W, {16'h7fff, 16'h0, 16'h0, 16'h0});
            write_reg(wtsp_pkg::REG_VIEW_W, ph ? 64'd4095 : 64'd0);
            write_reg(wtsp_pkg::REG_VIEW_H, ph ? 64'd4095 : 64'd0);
            write_reg(wtsp_pkg::REG_ORIGIN_X, ph ? 64'h800 : 64'h7ff);
            write_reg(wtsp_pkg::REG_ORIGIN_Y, ph ? 64'h7ff : 64'h800);
            for (int k = 0; k < 5; k++) send_point(rand_pos(), rand_pos(), rand_pos(), 0);
            i_valid <= 1'b0;
            drain_pipe();
        end

        // random phases
        for (int ph = 0; ph < 14; ph++) begin
            random_config(ph % 4 == 0);
            if (ph == 3) hold_off = 200;   // back the pipeline up
            if (ph >= 11) rx_idle_on = 1'b0;
            for (int k = 0; k < 120; k++)
                send_point(rand_pos(), rand_pos(), rand_pos(), ph < 11);
            i_valid <= 1'b0;
            drain_pipe();
        end

        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb_world_to_screen_projection_core passed");
        end else begin
            $display("tb_world_to_screen_projection_core failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
